FILE: design/seit_pkg.sv
// Package for the Sampson error inlier test.
// Holds the fixed formats, register codes and queue depth shared by all modules.
// No dependencies.
package seit_pkg;

  localparam int PT_FRAC     = 8;
  localparam int DEN_SHIFT   = 2 * PT_FRAC;
  localparam int ERR_W       = 32;
  localparam int ADDR_W      = 6;
  localparam int APB_DW      = 64;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    REG_PAIR_A = 3'd0,
    REG_PAIR_B = 3'd1,
    REG_PAIR_C = 3'd2,
    REG_PAIR_D = 3'd3,
    REG_LAST   = 3'd4,
    REG_THRESH = 3'd5
  } reg_idx_t;

endpackage

FILE: design/seit_front.sv
// Front part: takes an item and forms the epipolar line F*p1 and the first two terms of F^T*p2.
// Two register stages; uses seit_pkg.
module seit_front #(
  parameter int CW = 24,
  parameter int FW = 32,
  parameter int LW = FW + CW + 2,
  parameter int QW = 5 * LW + 2 * CW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic signed [CW-1:0] x1,
  input  logic signed [CW-1:0] y1,
  input  logic signed [CW-1:0] x2,
  input  logic signed [CW-1:0] y2,
  input  logic signed [FW-1:0] coef [9],
  output logic                 vld,
  output logic [QW-1:0]        data
);

  localparam int PW = FW + CW;

  logic signed [PW-1:0] m1_r [6];
  logic signed [PW-1:0] m2_r [4];
  logic signed [PW-1:0] h1_r [3];
  logic signed [PW-1:0] h2_r [2];
  logic signed [CW-1:0] x2_r, y2_r;
  logic                 v1_r;
  logic signed [LW-1:0] l1_nxt [3];
  logic signed [LW-1:0] l2_nxt [2];
  logic [QW-1:0]        data_r;
  logic                 v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      m1_r[2*k]   <= coef[3*k] * x1;
      m1_r[2*k+1] <= coef[3*k+1] * y1;
      h1_r[k]     <= PW'($signed({coef[3*k+2], {seit_pkg::PT_FRAC{1'b0}}}));
    end
    for (int k = 0; k < 2; k++) begin
      m2_r[2*k]   <= coef[k] * x2;
      m2_r[2*k+1] <= coef[3+k] * y2;
      h2_r[k]     <= PW'($signed({coef[6+k], {seit_pkg::PT_FRAC{1'b0}}}));
    end
    x2_r   <= x2;
    y2_r   <= y2;
    data_r <= {l1_nxt[0], l1_nxt[1], l1_nxt[2], l2_nxt[0], l2_nxt[1], x2_r, y2_r};
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      l1_nxt[k] = LW'(m1_r[2*k]) + LW'(m1_r[2*k+1]) + LW'(h1_r[k]);
    end
    for (int k = 0; k < 2; k++) begin
      l2_nxt[k] = LW'(m2_r[2*k]) + LW'(m2_r[2*k+1]) + LW'(h2_r[k]);
    end
  end

  assign vld  = v2_r;
  assign data = data_r;

endmodule

FILE: design/seit_queue.sv
// Short queue between the front and back parts, drained whenever it holds an item.
// Memory with registered read; uses seit_pkg.
module seit_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  output logic         dvalid,
  output logic [W-1:0] dout
);

  localparam int DEPTH = seit_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          pop;
  logic [W-1:0]  dout_r;
  logic          dvalid_r;

  assign pop  = (cnt_r != '0);
  assign full = (cnt_r == (AW+1)'(DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      rp_r     <= '0;
      cnt_r    <= '0;
      dvalid_r <= 1'b0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
      dvalid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= din;
    end
    dout_r <= mem[rp_r];
  end

  assign dvalid = dvalid_r;
  assign dout   = dout_r;

endmodule

FILE: design/seit_back.sv
// Back part: residual, squared line terms and the numerator and denominator.
// Five register stages of split multiplications; uses seit_pkg.
module seit_back #(
  parameter int CW = 24,
  parameter int FW = 32,
  parameter int EF = 16,
  parameter int LW = FW + CW + 2,
  parameter int RW = CW + LW + 2,
  parameter int QW = 5 * LW + 2 * CW,
  parameter int NW = 2 * RW + EF,
  parameter int DW = 2 * LW + 2 + seit_pkg::DEN_SHIFT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld,
  input  logic [QW-1:0] data,
  output logic          o_vld,
  output logic [NW-1:0] o_num,
  output logic [DW-1:0] o_den,
  output logic          o_degen
);

  localparam int H  = (LW + 1) / 2;
  localparam int B  = (RW + 2) / 3;
  localparam int SW = 2 * LW + 2;

  logic signed [LW-1:0] l1 [3];
  logic signed [LW-1:0] l2 [2];
  logic signed [CW-1:0] px, py;
  logic signed [LW-1:0] lsel [4];
  logic signed [CW-1:0] psel_c [2];
  logic [LW-1:0]        al_c [4];
  logic [2*H-1:0]       alx_c [4];
  logic [CW-1:0]        ap_c [2];

  logic [CW+H-1:0]      pl_r [2];
  logic [CW+H-1:0]      ph_r [2];
  logic                 sg_r [2];
  logic signed [LW-1:0] l12_r;
  logic [2*H-1:0]       al_r [4];

  logic signed [RW-1:0] rt_r [3];
  logic [2*H-1:0]       shh_r [4];
  logic [2*H-1:0]       shl_r [4];
  logic [2*H-1:0]       sll_r [4];

  logic [RW-1:0]        ares_r;
  logic [2*LW-1:0]      lsq_r [4];

  logic [2*B-1:0]       p00_r, p11_r, p22_r, p01_r, p02_r, p12_r;
  logic [SW-1:0]        sq_r;

  logic [NW-1:0]        num_r;
  logic [DW-1:0]        den_r;
  logic                 degen_r;
  logic [4:0]           v_r;

  logic [CW+2*H-1:0]    mag_c [2];
  logic signed [RW-1:0] res_c;
  logic [4*H-1:0]       sqf_c [4];
  logic [3*B-1:0]       arx_c;
  logic [6*B-1:0]       r2_c;

  assign {l1[0], l1[1], l1[2], l2[0], l2[1], px, py} = data;

  always_comb begin
    lsel[0]   = l1[0];
    lsel[1]   = l1[1];
    lsel[2]   = l2[0];
    lsel[3]   = l2[1];
    psel_c[0] = px;
    psel_c[1] = py;
    for (int i = 0; i < 4; i++) begin
      al_c[i]  = lsel[i][LW-1] ? $unsigned(-lsel[i]) : $unsigned(lsel[i]);
      alx_c[i] = (2*H)'(al_c[i]);
    end
    for (int i = 0; i < 2; i++) begin
      ap_c[i]  = psel_c[i][CW-1] ? $unsigned(-psel_c[i]) : $unsigned(psel_c[i]);
      mag_c[i] = {ph_r[i], {H{1'b0}}} + (CW+2*H)'(pl_r[i]);
    end
    res_c = rt_r[0] + rt_r[1] + rt_r[2];
    for (int i = 0; i < 4; i++) begin
      sqf_c[i] = (4*H)'({shh_r[i], {(2*H){1'b0}}}) + (4*H)'({shl_r[i], {(H+1){1'b0}}})
               + (4*H)'(sll_r[i]);
    end
    arx_c = (3*B)'(ares_r);
    r2_c  = (6*B)'({p22_r, {(4*B){1'b0}}}) + (6*B)'({p11_r, {(2*B){1'b0}}})
          + (6*B)'(p00_r) + (6*B)'({p01_r, {(B+1){1'b0}}})
          + (6*B)'({p02_r, {(2*B+1){1'b0}}}) + (6*B)'({p12_r, {(3*B+1){1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      pl_r[i] <= ap_c[i] * alx_c[i][H-1:0];
      ph_r[i] <= ap_c[i] * alx_c[i][2*H-1:H];
      sg_r[i] <= psel_c[i][CW-1] ^ lsel[i][LW-1];
    end
    l12_r <= l1[2];
    for (int i = 0; i < 4; i++) begin
      al_r[i] <= alx_c[i];
    end

    for (int i = 0; i < 2; i++) begin
      rt_r[i] <= sg_r[i] ? -$signed(RW'(mag_c[i])) : $signed(RW'(mag_c[i]));
    end
    rt_r[2] <= RW'($signed({l12_r, {seit_pkg::PT_FRAC{1'b0}}}));
    for (int i = 0; i < 4; i++) begin
      shh_r[i] <= al_r[i][2*H-1:H] * al_r[i][2*H-1:H];
      shl_r[i] <= al_r[i][2*H-1:H] * al_r[i][H-1:0];
      sll_r[i] <= al_r[i][H-1:0] * al_r[i][H-1:0];
    end

    ares_r <= res_c[RW-1] ? $unsigned(-res_c) : $unsigned(res_c);
    for (int i = 0; i < 4; i++) begin
      lsq_r[i] <= sqf_c[i][2*LW-1:0];
    end

    p00_r <= arx_c[B-1:0] * arx_c[B-1:0];
    p11_r <= arx_c[2*B-1:B] * arx_c[2*B-1:B];
    p22_r <= arx_c[3*B-1:2*B] * arx_c[3*B-1:2*B];
    p01_r <= arx_c[B-1:0] * arx_c[2*B-1:B];
    p02_r <= arx_c[B-1:0] * arx_c[3*B-1:2*B];
    p12_r <= arx_c[2*B-1:B] * arx_c[3*B-1:2*B];
    sq_r  <= SW'(lsq_r[0]) + SW'(lsq_r[1]) + SW'(lsq_r[2]) + SW'(lsq_r[3]);

    num_r   <= {r2_c[2*RW-1:0], {EF{1'b0}}};
    den_r   <= {sq_r, {seit_pkg::DEN_SHIFT{1'b0}}};
    degen_r <= (sq_r == '0);
  end

  assign o_vld   = v_r[4];
  assign o_num   = num_r;
  assign o_den   = den_r;
  assign o_degen = degen_r;

endmodule

FILE: design/seit_div.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation,
// the inlier compare and the result register. Uses seit_pkg.
module seit_div #(
  parameter int NW = 184,
  parameter int DW = 134
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld,
  input  logic [NW-1:0]              num,
  input  logic [DW-1:0]              den,
  input  logic                       degen,
  input  logic [seit_pkg::ERR_W-1:0] thr,
  output logic                       o_vld,
  output logic [seit_pkg::ERR_W-1:0] o_error,
  output logic                       o_inlier,
  output logic                       o_degen
);

  localparam int QW  = seit_pkg::ERR_W;
  localparam int CMW = (NW > DW + QW) ? NW : DW + QW;

  logic [CMW-1:0] rem_r [QW];
  logic [DW-1:0]  den_r [QW];
  logic [QW-1:0]  q_r   [QW+1];
  logic           frc_r [QW+1];
  logic           dg_r  [QW+1];
  logic           v_r   [QW+1];

  logic [QW-1:0]  err_c;
  logic [QW-1:0]  err_r;
  logic           inl_r, dgo_r, vo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= CMW'(num);
    den_r[0] <= den;
    q_r[0]   <= '0;
    frc_r[0] <= degen | (CMW'(num) >= (CMW'(den) << QW));
    dg_r[0]  <= degen;
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    logic [CMW-1:0] t_c;
    logic           ge_c;

    assign t_c  = CMW'(den_r[j-1]) << (QW - j);
    assign ge_c = (rem_r[j-1] >= t_c);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else begin
        v_r[j] <= v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      q_r[j]   <= {q_r[j-1][QW-2:0], ge_c};
      frc_r[j] <= frc_r[j-1];
      dg_r[j]  <= dg_r[j-1];
    end

    if (j < QW) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[j] <= ge_c ? (rem_r[j-1] - t_c) : rem_r[j-1];
        den_r[j] <= den_r[j-1];
      end
    end
  end

  assign err_c = frc_r[QW] ? '1 : q_r[QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    err_r <= err_c;
    inl_r <= (err_c < thr);
    dgo_r <= dg_r[QW];
  end

  assign o_vld    = vo_r;
  assign o_error  = err_r;
  assign o_inlier = inl_r;
  assign o_degen  = dgo_r;

endmodule

FILE: design/sampson_error_inlier_test.sv
// Top level of the Sampson error inlier test: register port, front, queue, back, divider.
// Depends on seit_pkg, seit_front, seit_queue, seit_back and seit_div.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------------
//   input    | start / busy                | in_x1, in_y1, in_x2, in_y2
//   result   | out_valid (one-cycle)       | out_error, out_inlier, out_degenerate
//   config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One item is taken every cycle while busy is low; each result passes through the front,
// queue, back and divider, the latter a 32-stage division pipeline.
// Reset is synchronous and active low; it clears the config registers, the queue pointers and all valid flags.
// The result side cannot stall, so the queue always drains and busy stays low.
module sampson_error_inlier_test #(
  parameter int COORD_WIDTH     = 24,
  parameter int COEF_WIDTH      = 32,
  parameter int ERROR_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_x1,
  input  logic signed [COORD_WIDTH-1:0] in_y1,
  input  logic signed [COORD_WIDTH-1:0] in_x2,
  input  logic signed [COORD_WIDTH-1:0] in_y2,
  output logic                          out_valid,
  output logic [seit_pkg::ERR_W-1:0]    out_error,
  output logic                          out_inlier,
  output logic                          out_degenerate,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [seit_pkg::ADDR_W-1:0]   paddr,
  input  logic [seit_pkg::APB_DW-1:0]   pwdata,
  output logic [seit_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int LW = COEF_WIDTH + COORD_WIDTH + 2;
  localparam int RW = COORD_WIDTH + LW + 2;
  localparam int QW = 5 * LW + 2 * COORD_WIDTH;
  localparam int NW = 2 * RW + ERROR_FRAC_BITS;
  localparam int DW = 2 * LW + 2 + seit_pkg::DEN_SHIFT;

  logic [63:0] coef_pair_a_r, coef_pair_b_r, coef_pair_c_r, coef_pair_d_r;
  logic [31:0] coef_last_r, threshold_sq_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  logic signed [COEF_WIDTH-1:0] coef [9];

  logic          acc;
  logic          f_vld;
  logic [QW-1:0] f_data;
  logic          q_full;
  logic          q_vld;
  logic [QW-1:0] q_data;
  logic          b_vld;
  logic [NW-1:0] b_num;
  logic [DW-1:0] b_den;
  logic          b_degen;

  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_pair_a_r  <= '0;
      coef_pair_b_r  <= '0;
      coef_pair_c_r  <= '0;
      coef_pair_d_r  <= '0;
      coef_last_r    <= '0;
      threshold_sq_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        seit_pkg::REG_PAIR_A: coef_pair_a_r  <= pwdata;
        seit_pkg::REG_PAIR_B: coef_pair_b_r  <= pwdata;
        seit_pkg::REG_PAIR_C: coef_pair_c_r  <= pwdata;
        seit_pkg::REG_PAIR_D: coef_pair_d_r  <= pwdata;
        seit_pkg::REG_LAST:   coef_last_r    <= pwdata[31:0];
        seit_pkg::REG_THRESH: threshold_sq_r <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      seit_pkg::REG_PAIR_A: prdata = coef_pair_a_r;
      seit_pkg::REG_PAIR_B: prdata = coef_pair_b_r;
      seit_pkg::REG_PAIR_C: prdata = coef_pair_c_r;
      seit_pkg::REG_PAIR_D: prdata = coef_pair_d_r;
      seit_pkg::REG_LAST:   prdata = 64'(coef_last_r);
      seit_pkg::REG_THRESH: prdata = 64'(threshold_sq_r);
      default:              prdata = '0;
    endcase
  end

  assign coef[0] = coef_pair_a_r[COEF_WIDTH-1:0];
  assign coef[1] = coef_pair_a_r[32+COEF_WIDTH-1:32];
  assign coef[2] = coef_pair_b_r[COEF_WIDTH-1:0];
  assign coef[3] = coef_pair_b_r[32+COEF_WIDTH-1:32];
  assign coef[4] = coef_pair_c_r[COEF_WIDTH-1:0];
  assign coef[5] = coef_pair_c_r[32+COEF_WIDTH-1:32];
  assign coef[6] = coef_pair_d_r[COEF_WIDTH-1:0];
  assign coef[7] = coef_pair_d_r[32+COEF_WIDTH-1:32];
  assign coef[8] = coef_last_r[COEF_WIDTH-1:0];

  assign busy = q_full;
  assign acc  = start & ~busy;

  seit_front #(
    .CW (COORD_WIDTH),
    .FW (COEF_WIDTH)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .x1    (in_x1),
    .y1    (in_y1),
    .x2    (in_x2),
    .y2    (in_y2),
    .coef  (coef),
    .vld   (f_vld),
    .data  (f_data)
  );

  seit_queue #(
    .W (QW)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (f_vld),
    .din    (f_data),
    .full   (q_full),
    .dvalid (q_vld),
    .dout   (q_data)
  );

  seit_back #(
    .CW (COORD_WIDTH),
    .FW (COEF_WIDTH),
    .EF (ERROR_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld     (q_vld),
    .data    (q_data),
    .o_vld   (b_vld),
    .o_num   (b_num),
    .o_den   (b_den),
    .o_degen (b_degen)
  );

  seit_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld      (b_vld),
    .num      (b_num),
    .den      (b_den),
    .degen    (b_degen),
    .thr      (threshold_sq_r),
    .o_vld    (out_valid),
    .o_error  (out_error),
    .o_inlier (out_inlier),
    .o_degen  (out_degenerate)
  );

endmodule
